FILE: rtl/fps_pkg.sv
// Shared constants and types for the fire pixel shader.
package fps_pkg;

  // Largest LED grid, in cells, that the shader accepts.
  localparam int unsigned MaxCellsDefault = 1024;

  // Field widths.
  localparam int unsigned PosW   = 10;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned GridW  = 11;
  localparam int unsigned CellsW = 2 * GridW;

  // Stream and configuration port widths.
  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_GRID_WIDTH    = 3'd0,
    REG_GRID_HEIGHT   = 3'd1,
    REG_COOLING_GAIN  = 3'd2,
    REG_HUE_SPREAD    = 3'd3,
    REG_REVERSE_ORDER = 3'd4
  } cfg_reg_t;

  // Configuration reset values.
  localparam logic [GridW-1:0] GridWidthReset    = 11'd8;
  localparam logic [GridW-1:0] GridHeightReset   = 11'd8;
  localparam logic [ByteW-1:0] CoolingGainReset  = 8'd64;
  localparam logic [ByteW-1:0] HueSpreadReset    = 8'd64;

  // Hue sector codes of the six-sector HSV rule.
  typedef enum logic [2:0] {
    SECT_RED_YEL  = 3'd0,
    SECT_YEL_GRN  = 3'd1,
    SECT_GRN_CYN  = 3'd2,
    SECT_CYN_BLU  = 3'd3,
    SECT_BLU_MAG  = 3'd4,
    SECT_MAG_RED  = 3'd5
  } sector_t;

  // Scale a Q16 color component to an 8-bit channel: floor(c * 255 / 65536).
  function automatic logic [ByteW-1:0] to_channel(input logic [15:0] c16);
    logic [23:0] prod;
    prod = {c16, 8'd0} - {8'd0, c16};
    return prod[23:16];
  endfunction

endpackage

FILE: rtl/fire_pixel_shader.sv
// Fire effect LED shader: heat blend, cooling, hue offset, HSV to RGB and LED index.
//
//  Channel | Handshake               | Payload
//  --------+-------------------------+------------------------------------------------
//  in_     | in_tvalid / in_tready   | in_tdata: col, row, heat_here, heat_below,
//          |                         |           blend_phase, cooling_mask,
//          |                         |           hue_offset_mask, frame_hue
//  out_    | out_tvalid / out_tready | out_tdata: led_index, red, green, blue
//  cfg_    | cfg_we (no wait)        | cfg_index, cfg_wdata
//
// One item per clock sustained while the output is not stalled; each item passes five
// register stages (products, value and index, sector, HSV products, channels) before it
// is presented at the output.
// Items off the grid, or on a grid that is empty or too large, are dropped inside
// the pipeline and give no result.
// Each stage holds its valid bit and advances when the stage after it is empty or
// moving, so a stall at the output backs up only as far as it must.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module fire_pixel_shader #(
  parameter int unsigned MAX_CELLS = fps_pkg::MaxCellsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input stream.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // [9:0] cell_col, [19:10] cell_row, [27:20] heat_here, [35:28] heat_below,
  // [43:36] blend_phase, [51:44] cooling_mask, [59:52] hue_offset_mask,
  // [67:60] frame_hue, [71:68] zero
  input  logic [fps_pkg::InDataW-1:0]  in_tdata,
  // Result stream.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // [9:0] led_index, [17:10] red, [25:18] green, [33:26] blue, [39:34] zero
  output logic [fps_pkg::OutDataW-1:0] out_tdata,
  // Configuration write port.
  input  logic                         cfg_we,
  input  logic [fps_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fps_pkg::CfgDataW-1:0] cfg_wdata
);
  import fps_pkg::*;

  // Configuration registers.
  logic [GridW-1:0] grid_width_r;
  logic [GridW-1:0] grid_height_r;
  logic [ByteW-1:0] cooling_gain_r;
  logic [ByteW-1:0] hue_spread_r;
  logic             reverse_order_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r    <= GridWidthReset;
      grid_height_r   <= GridHeightReset;
      cooling_gain_r  <= CoolingGainReset;
      hue_spread_r    <= HueSpreadReset;
      reverse_order_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:    grid_width_r    <= cfg_wdata;
        REG_GRID_HEIGHT:   grid_height_r   <= cfg_wdata;
        REG_COOLING_GAIN:  cooling_gain_r  <= cfg_wdata[ByteW-1:0];
        REG_HUE_SPREAD:    hue_spread_r    <= cfg_wdata[ByteW-1:0];
        REG_REVERSE_ORDER: reverse_order_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [PosW-1:0]  in_col, in_row;
  logic [ByteW-1:0] in_here, in_below, in_phase, in_cmask, in_hmask, in_base;

  assign in_col   = in_tdata[9:0];
  assign in_row   = in_tdata[19:10];
  assign in_here  = in_tdata[27:20];
  assign in_below = in_tdata[35:28];
  assign in_phase = in_tdata[43:36];
  assign in_cmask = in_tdata[51:44];
  assign in_hmask = in_tdata[59:52];
  assign in_base  = in_tdata[67:60];

  // Stage valid bits and per-stage advance.
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;

  assign s5_rdy    = !s5_vld_r || out_tready;
  assign s4_rdy    = !s4_vld_r || s5_rdy;
  assign s3_rdy    = !s3_vld_r || s4_rdy;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_tready = s1_rdy;

  // Stage 1: blend, cooling and spread products; grid size and row offset.
  logic [8:0]        phase_inv;
  logic [GridW-1:0]  rows_above;
  logic              in_grid;

  logic [16:0]       s1_here_prod_r;
  logic [15:0]       s1_below_prod_r;
  logic [15:0]       s1_cool_r;
  logic [15:0]       s1_spread_r;
  logic [ByteW-1:0]  s1_base_r;
  logic [CellsW-1:0] s1_total_r;
  logic [CellsW-1:0] s1_row_base_r;
  logic [PosW-1:0]   s1_col_r;
  logic              s1_rev_r;
  logic              s1_in_grid_r;

  assign phase_inv  = 9'd256 - {1'b0, in_phase};
  assign rows_above = grid_height_r - GridW'(1) - {1'b0, in_row};
  assign in_grid    = ({1'b0, in_col} < grid_width_r) && ({1'b0, in_row} < grid_height_r);

  always_ff @(posedge clk) begin
    if (s1_rdy) begin
      s1_here_prod_r  <= 17'(phase_inv) * 17'(in_here);
      s1_below_prod_r <= 16'(in_phase) * 16'(in_below);
      s1_cool_r       <= 16'(in_cmask) * 16'(cooling_gain_r);
      s1_spread_r     <= 16'(in_hmask) * 16'(hue_spread_r);
      s1_base_r       <= in_base;
      s1_total_r      <= CellsW'(grid_width_r) * CellsW'(grid_height_r);
      s1_row_base_r   <= CellsW'(rows_above) * CellsW'(grid_width_r);
      s1_col_r        <= in_col;
      s1_rev_r        <= reverse_order_r;
      s1_in_grid_r    <= in_grid;
    end
  end

  // Stage 2: saturated value, wrapped hue and LED index; filter off-grid items.
  logic [17:0]       blend, cool4, diff;
  logic [ByteW-1:0]  val_nxt, hue_nxt;
  logic [CellsW-1:0] idx_fwd, idx_nxt;
  logic              keep;

  logic [ByteW-1:0]  s2_val_r;
  logic [ByteW-1:0]  s2_hue_r;
  logic [PosW-1:0]   s2_idx_r;
  logic              s2_keep_r;

  always_comb begin
    blend = 18'(s1_here_prod_r) + 18'(s1_below_prod_r);
    cool4 = {s1_cool_r, 2'b00};
    diff  = blend - cool4;
    if (blend <= cool4) begin
      val_nxt = '0;
    end else if (diff[17:16] != 2'b00) begin
      val_nxt = 8'hFF;
    end else begin
      val_nxt = diff[15:8];
    end
    hue_nxt = s1_base_r + s1_spread_r[13:6];
    idx_fwd = s1_row_base_r + CellsW'(s1_col_r);
    idx_nxt = s1_rev_r ? (s1_total_r - CellsW'(1) - idx_fwd) : idx_fwd;
    keep    = s1_in_grid_r && (s1_total_r != '0)
              && (s1_total_r <= CellsW'(MAX_CELLS)) && (idx_nxt < s1_total_r);
  end

  always_ff @(posedge clk) begin
    if (s2_rdy) begin
      s2_val_r  <= val_nxt;
      s2_hue_r  <= hue_nxt;
      s2_idx_r  <= idx_nxt[PosW-1:0];
      s2_keep_r <= keep;
    end
  end

  // Stage 3: hue sector and the Q16 factors for the falling and rising ramps.
  logic [10:0]      h6;
  logic [15:0]      frac255;
  logic [16:0]      q_fac_nxt, t_fac_nxt;

  logic [ByteW-1:0] s3_val_r;
  logic [2:0]       s3_sector_r;
  logic [16:0]      s3_q_fac_r, s3_t_fac_r;
  logic [PosW-1:0]  s3_idx_r;

  assign h6        = {1'b0, s2_hue_r, 2'b00} + {2'b00, s2_hue_r, 1'b0};
  assign frac255   = {h6[7:0], 8'd0} - {8'd0, h6[7:0]};
  assign q_fac_nxt = 17'h10000 - 17'(frac255);
  assign t_fac_nxt = 17'd256 + 17'(frac255);

  always_ff @(posedge clk) begin
    if (s3_rdy) begin
      s3_val_r    <= s2_val_r;
      s3_sector_r <= h6[10:8];
      s3_q_fac_r  <= q_fac_nxt;
      s3_t_fac_r  <= t_fac_nxt;
      s3_idx_r    <= s2_idx_r;
    end
  end

  // Stage 4: Q16 components V, P, Q and T.
  logic [24:0]      q_prod, t_prod;
  logic [15:0]      s4_v16_r, s4_p16_r, s4_q16_r, s4_t16_r;
  logic [2:0]       s4_sector_r;
  logic [PosW-1:0]  s4_idx_r;

  assign q_prod = 25'(s3_val_r) * 25'(s3_q_fac_r);
  assign t_prod = 25'(s3_val_r) * 25'(s3_t_fac_r);

  always_ff @(posedge clk) begin
    if (s4_rdy) begin
      s4_v16_r    <= {s3_val_r, 8'd0};
      s4_p16_r    <= 16'(s3_val_r);
      s4_q16_r    <= q_prod[23:8];
      s4_t16_r    <= t_prod[23:8];
      s4_sector_r <= s3_sector_r;
      s4_idx_r    <= s3_idx_r;
    end
  end

  // Stage 5: sector select and channel scaling into the output register.
  logic [15:0]      r16, g16, b16;
  logic [ByteW-1:0] s5_red_r, s5_green_r, s5_blue_r;
  logic [PosW-1:0]  s5_idx_r;

  always_comb begin
    unique case (s4_sector_r)
      SECT_RED_YEL: begin r16 = s4_v16_r; g16 = s4_t16_r; b16 = s4_p16_r; end
      SECT_YEL_GRN: begin r16 = s4_q16_r; g16 = s4_v16_r; b16 = s4_p16_r; end
      SECT_GRN_CYN: begin r16 = s4_p16_r; g16 = s4_v16_r; b16 = s4_t16_r; end
      SECT_CYN_BLU: begin r16 = s4_p16_r; g16 = s4_q16_r; b16 = s4_v16_r; end
      SECT_BLU_MAG: begin r16 = s4_t16_r; g16 = s4_p16_r; b16 = s4_v16_r; end
      default:      begin r16 = s4_v16_r; g16 = s4_p16_r; b16 = s4_q16_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s5_rdy) begin
      s5_red_r   <= to_channel(r16);
      s5_green_r <= to_channel(g16);
      s5_blue_r  <= to_channel(b16);
      s5_idx_r   <= s4_idx_r;
    end
  end

  // Valid bits; off-grid items leave the pipeline after stage 2.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (s1_rdy) s1_vld_r <= in_tvalid;
      if (s2_rdy) s2_vld_r <= s1_vld_r;
      if (s3_rdy) s3_vld_r <= s2_vld_r && s2_keep_r;
      if (s4_rdy) s4_vld_r <= s3_vld_r;
      if (s5_rdy) s5_vld_r <= s4_vld_r;
    end
  end

  assign out_tvalid = s5_vld_r;
  assign out_tdata  = {6'd0, s5_blue_r, s5_green_r, s5_red_r, s5_idx_r};

`ifndef SYNTHESIS
  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // The two ramp factors always sum to one in Q16 plus the P level.
  a_ramp_sum: assert property (@(posedge clk) disable iff (!rst_n)
    s3_vld_r |-> (18'(s3_q_fac_r) + 18'(s3_t_fac_r) == 18'd65792))
    else $error("hue ramp factors inconsistent");

  // P is the smallest component and V the largest.
  a_comp_order: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r |-> (s4_p16_r <= s4_q16_r) && (s4_p16_r <= s4_t16_r)
                 && (s4_q16_r <= s4_v16_r) && (s4_t16_r <= s4_v16_r))
    else $error("HSV component ordering broken");

  // A stalled stage 4 holds its item until the next stage takes it.
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s4_vld_r && !s4_rdy |=> s4_vld_r && $stable(s4_idx_r) && $stable(s4_v16_r))
    else $error("stalled item lost in stage 4");

  // A dropped item never reaches stage 3.
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r && !s2_keep_r && s3_rdy |=> !s3_vld_r)
    else $error("off-grid item passed the filter");
`endif

endmodule
